>>> rtl/bpa_pkg.sv
// Shared types, constants and helper functions for the buddy page allocator.
// Used by bpa_ctrl, buddy_page_allocator and the testbench; depends on nothing else.
`default_nettype none

package bpa_pkg;

    localparam int MAX_ORDER  = 15;
    localparam int PAGE_SHIFT = 12;

    localparam int ADDR_W   = 27;
    localparam int LIMIT_W  = 28;
    localparam int COUNT_W  = 16;
    localparam int BORD_W   = 4;
    localparam int STATUS_W = 3;

    localparam int PG_W    = MAX_ORDER + 1;
    localparam int ORD_W   = $clog2(MAX_ORDER + 1);
    localparam int WORD_W  = 64;
    localparam int BIT_W   = 6;
    localparam int WORD_AW = (MAX_ORDER >= 6) ? (MAX_ORDER - 5) : 1;
    localparam int WORDS   = 1 << WORD_AW;
    localparam int IDX_W   = WORD_AW + BIT_W;
    localparam int P_W     = ADDR_W - PAGE_SHIFT;
    localparam int SUM_W   = ((COUNT_W > PG_W) ? ((COUNT_W > P_W) ? COUNT_W : P_W)
                                               : ((PG_W > P_W) ? PG_W : P_W)) + 1;
    localparam int POOL_PAGES = 1 << MAX_ORDER;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1) << ADDR_W;

    typedef enum logic [1:0] {
        MODE_ALLOC_CNT = 2'd0,
        MODE_ALLOC_ORD = 2'd1,
        MODE_FREE_CNT  = 2'd2,
        MODE_FREE_ORD  = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_NOMEM      = 3'd1,
        ST_BADCOUNT   = 3'd2,
        ST_RANGE      = 3'd3,
        ST_PAGEALIGN  = 3'd4,
        ST_BLOCKALIGN = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        OP_ALLOC    = 2'd0,
        OP_FREE_RUN = 2'd1,
        OP_FREE_BLK = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0]         mode;
        logic [ADDR_W-1:0]  byte_address;
        logic [COUNT_W-1:0] page_count;
        logic [BORD_W-1:0]  block_order;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   alloc_address;
    } t_out_item;

    // Command from the front end to the sequencer.
    typedef struct packed {
        logic             valid;
        t_op              op;
        logic             by_count;
        logic [ORD_W-1:0] k;
        logic [PG_W-1:0]  p;
        logic [PG_W-1:0]  c;
    } t_cmd;

    typedef struct packed {
        logic            ready;
        logic            done;
        logic            nomem;
        logic [PG_W-1:0] page;
    } t_rsp;

    // Flat bit position of block b of order k.
    function automatic logic [IDX_W-1:0] bit_idx(input logic [ORD_W-1:0] k,
                                                 input logic [PG_W-1:0] b);
        logic [IDX_W-1:0] base;
        base = IDX_W'(1) << (MAX_ORDER - int'(k));
        return base + IDX_W'(b);
    endfunction

    // Trailing zeros, saturating at MAX_ORDER.
    function automatic logic [ORD_W-1:0] ctz_cap(input logic [PG_W-1:0] p);
        logic [ORD_W-1:0] res;
        res = ORD_W'(MAX_ORDER);
        for (int i = PG_W - 1; i >= 0; i--) begin
            if (p[i]) res = ORD_W'(i);
        end
        return res;
    endfunction

    function automatic logic [ORD_W-1:0] flog2(input logic [PG_W-1:0] c);
        logic [ORD_W-1:0] res;
        res = '0;
        for (int i = 0; i < PG_W; i++) begin
            if (c[i]) res = ORD_W'(i);
        end
        return res;
    endfunction

    // Smallest k with 2^k >= cnt, for a count between one and the pool size.
    function automatic logic [ORD_W-1:0] clog2_cnt(input logic [COUNT_W-1:0] cnt);
        logic [COUNT_W-1:0] m;
        logic [ORD_W-1:0]   res;
        m   = cnt - COUNT_W'(1);
        res = '0;
        for (int i = 0; i < COUNT_W; i++) begin
            if (m[i]) res = ORD_W'(i + 1);
        end
        return res;
    endfunction

    function automatic logic [BIT_W-1:0] ffs64(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] res;
        res = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (w[i]) res = BIT_W'(i);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/bpa_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Self-contained; no package needed.
`default_nettype none

module bpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/bpa_ctrl.sv
// Sequencer for the allocator: bitmap clearing pass, lowest-block scan,
// splitting, and buddy merging, all through one read-modify-write word path.
// Depends on bpa_pkg and bpa_ram.
`default_nettype none

module bpa_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire bpa_pkg::t_cmd i_cmd,
    output bpa_pkg::t_rsp      o_rsp
);
    import bpa_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SCAN, S_SP_RD, S_SP_MOD, S_AEND,
        S_FR_STEP, S_FB_RD, S_FB_MOD
    } t_state;

    t_state r_state, n_state;

    logic [WORD_AW:0]   r_w, n_w, r_wend, n_wend;
    logic               r_chk, n_chk;
    logic [WORD_AW-1:0] r_chk_addr, n_chk_addr;
    logic [WORD_W-1:0]  r_mask, n_mask;
    logic [IDX_W-1:0]   r_n, n_n;
    logic [ORD_W-1:0]   r_j, n_j, r_k, n_k;
    logic [PG_W-1:0]    r_b, n_b, r_p, n_p, r_c, n_c, r_page, n_page;
    logic               r_by_count, n_by_count;
    logic               r_done, n_done, r_nomem, n_nomem;
    logic [PG_W-1:0]    r_cnt [MAX_ORDER+1];

    logic               ram_we;
    logic [WORD_AW-1:0] ram_waddr, ram_raddr;
    logic [WORD_W-1:0]  ram_wdata, ram_rdata;

    logic               cnt_inc, cnt_dec;
    logic [ORD_W-1:0]   cnt_sel;
    logic [MAX_ORDER:0] nonempty;
    logic               j_found;
    logic [ORD_W-1:0]   j_hit;
    logic [IDX_W-1:0]   scan_n;
    logic               scan_big;
    logic [WORD_AW:0]   scan_start;
    logic [WORD_W-1:0]  scan_mask, scan_bits;
    logic [BIT_W-1:0]   scan_t;
    logic [IDX_W-1:0]   idx_sp_rd, idx_sp, idx_own, idx_bud;
    logic [ORD_W-1:0]   fr_k, fr_tz, fr_lg;
    logic [PG_W-1:0]    a_page, a_rem;

    bpa_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_bitmap (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        for (int i = 0; i <= MAX_ORDER; i++) begin
            nonempty[i] = (r_cnt[i] != '0);
        end
        // Smallest non-empty order at or above the requested one.
        j_found = 1'b0;
        j_hit   = '0;
        for (int i = MAX_ORDER; i >= 0; i--) begin
            if (nonempty[i] && (i >= int'(i_cmd.k))) begin
                j_found = 1'b1;
                j_hit   = ORD_W'(i);
            end
        end
        scan_n     = IDX_W'(1) << (MAX_ORDER - int'(j_hit));
        scan_big   = |scan_n[IDX_W-1:BIT_W];
        scan_start = scan_big ? {1'b0, scan_n[IDX_W-1:BIT_W]} : '0;
        for (int t = 0; t < WORD_W; t++) begin
            scan_mask[t] = scan_big ||
                           ((t >= int'(scan_n)) && (t < 2 * int'(scan_n)));
        end
        scan_bits = ram_rdata & r_mask;
        scan_t    = ffs64(scan_bits);
        idx_sp_rd = bit_idx(r_j - ORD_W'(1), {r_b[PG_W-2:0], 1'b1});
        idx_sp    = bit_idx(r_j, r_b | PG_W'(1));
        idx_own   = bit_idx(r_k, r_b);
        idx_bud   = bit_idx(r_k, r_b ^ PG_W'(1));
        fr_tz     = ctz_cap(r_p);
        fr_lg     = flog2(r_c);
        fr_k      = (fr_tz < fr_lg) ? fr_tz : fr_lg;
        a_page    = r_b << r_k;
        a_rem     = (PG_W'(1) << r_k) - r_c;
    end

    always_comb begin
        n_state    = r_state;
        n_w        = r_w;
        n_wend     = r_wend;
        n_chk      = r_chk;
        n_chk_addr = r_chk_addr;
        n_mask     = r_mask;
        n_n        = r_n;
        n_j        = r_j;
        n_k        = r_k;
        n_b        = r_b;
        n_p        = r_p;
        n_c        = r_c;
        n_page     = r_page;
        n_by_count = r_by_count;
        n_done     = 1'b0;
        n_nomem    = r_nomem;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = '0;
        ram_raddr  = '0;
        cnt_inc    = 1'b0;
        cnt_dec    = 1'b0;
        cnt_sel    = r_k;

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_w[WORD_AW-1:0];
                n_w       = r_w + 1'b1;
                if (r_w[WORD_AW-1:0] == {WORD_AW{1'b1}}) begin
                    n_w     = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_nomem = 1'b0;
                    case (i_cmd.op)
                        OP_ALLOC: begin
                            n_k        = i_cmd.k;
                            n_c        = i_cmd.c;
                            n_by_count = i_cmd.by_count;
                            if (!j_found) begin
                                n_nomem = 1'b1;
                                n_done  = 1'b1;
                            end else begin
                                n_j     = j_hit;
                                n_n     = scan_n;
                                n_w     = scan_start;
                                n_wend  = scan_big ? (scan_start << 1) : (WORD_AW + 1)'(1);
                                n_mask  = scan_mask;
                                n_chk   = 1'b0;
                                n_state = S_SCAN;
                            end
                        end
                        OP_FREE_RUN: begin
                            n_p     = i_cmd.p;
                            n_c     = i_cmd.c;
                            n_state = S_FR_STEP;
                        end
                        OP_FREE_BLK: begin
                            n_k     = i_cmd.k;
                            n_b     = i_cmd.p >> i_cmd.k;
                            n_c     = '0;
                            n_state = S_FB_RD;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Reads are issued one word ahead of the word being checked.
                ram_raddr  = r_w[WORD_AW-1:0];
                n_chk      = (r_w < r_wend);
                n_chk_addr = r_w[WORD_AW-1:0];
                if (r_w < r_wend) begin
                    n_w = r_w + 1'b1;
                end
                if (r_chk && (scan_bits != '0)) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_chk_addr;
                    ram_wdata = ram_rdata & ~(WORD_W'(1) << scan_t);
                    cnt_dec   = 1'b1;
                    cnt_sel   = r_j;
                    n_b       = PG_W'({r_chk_addr, scan_t} - r_n);
                    n_state   = (r_j > r_k) ? S_SP_RD : S_AEND;
                end else if (!r_chk && !(r_w < r_wend)) begin
                    n_nomem = 1'b1;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SP_RD: begin
                n_j       = r_j - ORD_W'(1);
                n_b       = {r_b[PG_W-2:0], 1'b0};
                ram_raddr = idx_sp_rd[IDX_W-1:BIT_W];
                n_state   = S_SP_MOD;
            end
            S_SP_MOD: begin
                // Free the upper half produced by this split.
                ram_we    = 1'b1;
                ram_waddr = idx_sp[IDX_W-1:BIT_W];
                ram_wdata = ram_rdata | (WORD_W'(1) << idx_sp[BIT_W-1:0]);
                cnt_inc   = !ram_rdata[idx_sp[BIT_W-1:0]];
                cnt_sel   = r_j;
                n_state   = (r_j > r_k) ? S_SP_RD : S_AEND;
            end
            S_AEND: begin
                n_page = a_page;
                if (r_by_count && (a_rem != '0)) begin
                    n_p     = a_page + r_c;
                    n_c     = a_rem;
                    n_state = S_FR_STEP;
                end else begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FR_STEP: begin
                n_k     = fr_k;
                n_b     = r_p >> fr_k;
                n_p     = r_p + (PG_W'(1) << fr_k);
                n_c     = r_c - (PG_W'(1) << fr_k);
                n_state = S_FB_RD;
            end
            S_FB_RD: begin
                ram_raddr = idx_own[IDX_W-1:BIT_W];
                n_state   = S_FB_MOD;
            end
            S_FB_MOD: begin
                // A block and its buddy always share one bitmap word.
                ram_we    = 1'b1;
                ram_waddr = idx_own[IDX_W-1:BIT_W];
                cnt_sel   = r_k;
                if ((int'(r_k) < MAX_ORDER) && ram_rdata[idx_bud[BIT_W-1:0]]) begin
                    ram_wdata = ram_rdata & ~(WORD_W'(1) << idx_bud[BIT_W-1:0]);
                    cnt_dec   = 1'b1;
                    n_k       = r_k + ORD_W'(1);
                    n_b       = r_b >> 1;
                    n_state   = S_FB_RD;
                end else begin
                    ram_wdata = ram_rdata | (WORD_W'(1) << idx_own[BIT_W-1:0]);
                    cnt_inc   = !ram_rdata[idx_own[BIT_W-1:0]];
                    if (r_c != '0) begin
                        n_state = S_FR_STEP;
                    end else begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_w     <= '0;
            r_chk   <= 1'b0;
            r_done  <= 1'b0;
            r_nomem <= 1'b0;
            for (int i = 0; i <= MAX_ORDER; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_w     <= n_w;
            r_chk   <= n_chk;
            r_done  <= n_done;
            r_nomem <= n_nomem;
            if (cnt_inc) begin
                r_cnt[cnt_sel] <= r_cnt[cnt_sel] + PG_W'(1);
            end else if (cnt_dec) begin
                r_cnt[cnt_sel] <= r_cnt[cnt_sel] - PG_W'(1);
            end
        end
        r_wend     <= n_wend;
        r_chk_addr <= n_chk_addr;
        r_mask     <= n_mask;
        r_n        <= n_n;
        r_j        <= n_j;
        r_k        <= n_k;
        r_b        <= n_b;
        r_p        <= n_p;
        r_c        <= n_c;
        r_page     <= n_page;
        r_by_count <= n_by_count;
    end

    assign o_rsp.ready = (r_state == S_IDLE);
    assign o_rsp.done  = r_done;
    assign o_rsp.nomem = r_nomem;
    assign o_rsp.page  = r_page;

    a_cmd_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.valid |-> (r_state == S_IDLE))
        else $error("command issued while the sequencer was busy");

    a_count_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_dec |-> (r_cnt[cnt_sel] != '0))
        else $error("free-block count decremented below zero");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("completion held for more than one cycle");

endmodule

`default_nettype wire

>>> rtl/buddy_page_allocator.sv
// Top level of the buddy page allocator: beat handshakes, request checks,
// limit register and result register. Depends on bpa_pkg and bpa_ctrl.
//
//   Channel   Direction  Handshake                 Beat contents
//   in        input      i_in_valid / o_in_stall   t_in_item request
//   out       output     o_out_valid / i_out_stall t_out_item result
//   cfg       input      i_cfg_we                  limit_address value
//
// After reset all WORDS (1024) words of the bitmap store are cleared; no request
// is taken meanwhile. A rejected request goes straight to the result register.
// An allocation scans one bitmap word per cycle (2^(MAX_ORDER-j)/64 words for
// order j, at least one), then reads and writes one word per split level, and
// a page-count allocation frees its unused tail. A freed block takes a read and
// a write per merge level and one more pair to set its bit; a page run is freed
// one aligned block at a time. One request is worked on at a time, but a new
// one is taken while the previous result still waits in the output register.
`default_nettype none

module buddy_page_allocator (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire bpa_pkg::t_in_item         i_in_data,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output bpa_pkg::t_out_item             o_out_data,
    input  wire logic                      i_cfg_we,
    input  wire logic [bpa_pkg::LIMIT_W-1:0] i_cfg_wdata
);
    import bpa_pkg::*;

    typedef enum logic [1:0] {T_IDLE, T_CHK, T_RUN, T_OUT} t_state;

    t_state             r_state;
    t_in_item           r_item;
    t_out_item          r_res;
    logic [LIMIT_W-1:0] r_limit;
    logic               r_is_alloc;

    t_cmd               cmd;
    t_rsp               rsp;
    t_status            chk_status;
    logic [P_W-1:0]     pg;
    logic [SUM_W-1:0]   end_cnt, end_ord, ord_size;
    logic               ord_bad;

    bpa_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd),
        .o_rsp  (rsp)
    );

    always_comb begin
        pg       = r_item.byte_address[ADDR_W-1:PAGE_SHIFT];
        ord_bad  = int'(r_item.block_order) > MAX_ORDER;
        ord_size = SUM_W'(1) << r_item.block_order;
        end_cnt  = SUM_W'(pg) + SUM_W'(r_item.page_count);
        end_ord  = SUM_W'(pg) + ord_size;

        chk_status = ST_OK;
        cmd        = '0;
        cmd.p      = PG_W'(pg);
        cmd.c      = PG_W'(r_item.page_count);
        cmd.k      = ORD_W'(r_item.block_order);
        unique case (r_item.mode)
            MODE_ALLOC_CNT: begin
                cmd.op       = OP_ALLOC;
                cmd.by_count = 1'b1;
                cmd.k        = clog2_cnt(r_item.page_count);
                if ((r_item.page_count == '0) ||
                    (SUM_W'(r_item.page_count) > SUM_W'(POOL_PAGES))) begin
                    chk_status = ST_BADCOUNT;
                end
            end
            MODE_ALLOC_ORD: begin
                cmd.op = OP_ALLOC;
                if (ord_bad) chk_status = ST_BADCOUNT;
            end
            MODE_FREE_CNT: begin
                cmd.op = OP_FREE_RUN;
                if ({1'b0, r_item.byte_address} >= r_limit) begin
                    chk_status = ST_RANGE;
                end else if (r_item.byte_address[PAGE_SHIFT-1:0] != '0) begin
                    chk_status = ST_PAGEALIGN;
                end else if (r_item.page_count == '0) begin
                    chk_status = ST_BADCOUNT;
                end else if (end_cnt > SUM_W'(POOL_PAGES)) begin
                    chk_status = ST_RANGE;
                end
            end
            MODE_FREE_ORD: begin
                cmd.op = OP_FREE_BLK;
                if ({1'b0, r_item.byte_address} >= r_limit) begin
                    chk_status = ST_RANGE;
                end else if (r_item.byte_address[PAGE_SHIFT-1:0] != '0) begin
                    chk_status = ST_PAGEALIGN;
                end else if (ord_bad || (end_ord > SUM_W'(POOL_PAGES))) begin
                    chk_status = ST_RANGE;
                end else if ((SUM_W'(pg) & (ord_size - SUM_W'(1))) != '0) begin
                    chk_status = ST_BLOCKALIGN;
                end
            end
            default: begin
                chk_status = ST_BADCOUNT;
            end
        endcase
        cmd.valid = (r_state == T_CHK) && (chk_status == ST_OK);
    end

    assign o_in_stall = (r_state != T_IDLE) || !rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_limit     <= LIMIT_RESET;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (o_out_valid && !i_out_stall && (r_state != T_OUT)) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                T_IDLE: begin
                    if (i_in_valid && !o_in_stall) begin
                        r_state <= T_CHK;
                    end
                end
                T_CHK: begin
                    r_res.status        <= chk_status;
                    r_res.alloc_address <= '0;
                    r_state             <= (chk_status == ST_OK) ? T_RUN : T_OUT;
                end
                T_RUN: begin
                    if (rsp.done) begin
                        r_res.status <= rsp.nomem ? ST_NOMEM : ST_OK;
                        r_res.alloc_address <= (r_is_alloc && !rsp.nomem)
                            ? ADDR_W'({rsp.page, {PAGE_SHIFT{1'b0}}}) : '0;
                        r_state <= T_OUT;
                    end
                end
                T_OUT: begin
                    if (!o_out_valid || !i_out_stall) begin
                        o_out_valid <= 1'b1;
                        o_out_data  <= r_res;
                        r_state     <= T_IDLE;
                    end
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
        end
        if (r_state == T_IDLE) begin
            r_item     <= i_in_data;
            r_is_alloc <= !i_in_data.mode[1];
        end
    end

endmodule

`default_nettype wire

>>> tb/buddy_page_allocator_checker.sv
// Checker for the buddy page allocator: predicts every result from the accepted
// request beats and compares it with the result beats. Depends on bpa_pkg.
`timescale 1ns / 1ps

module buddy_page_allocator_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  bpa_pkg::t_in_item           i_in_data,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  bpa_pkg::t_out_item          i_out_data,
    input  logic                        i_cfg_we,
    input  logic [bpa_pkg::LIMIT_W-1:0] i_cfg_wdata,
    output int                          o_fail_count,
    output int                          o_pending
);
    import bpa_pkg::*;

    localparam int MAP_SIZE = 2 ** (MAX_ORDER + 1);

    // One bit per block of every order; order k starts at 2^(MAX_ORDER-k).
    bit                 free_map [0:MAP_SIZE-1];
    logic [MAX_ORDER:0] order_busy;
    logic [LIMIT_W-1:0] free_limit;
    t_out_item          expected_q [$];

    function automatic int map_pos(input int k, input int b);
        return (1 << (MAX_ORDER - k)) + b;
    endfunction

    function automatic bit lowest_free(input int k, output int blk);
        int n;
        n = 1 << (MAX_ORDER - k);
        for (int b = 0; b < n; b++) begin
            if (free_map[n + b]) begin
                blk = b;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void refresh_order(input int k);
        int b;
        order_busy[k] = lowest_free(k, b);
    endfunction

    function automatic void release_block(input int k, input int b);
        while (k < MAX_ORDER && free_map[map_pos(k, b ^ 1)]) begin
            free_map[map_pos(k, b ^ 1)] = 1'b0;
            refresh_order(k);
            k++;
            b = b >> 1;
        end
        free_map[map_pos(k, b)] = 1'b1;
        order_busy[k] = 1'b1;
    endfunction

    // Frees a page run as maximal aligned blocks.
    function automatic void release_run(input longint p, input longint c);
        int k;
        while (c > 0) begin
            k = 0;
            while (k < MAX_ORDER && ((p >> (k + 1)) << (k + 1)) == p
                   && (64'd1 << (k + 1)) <= c)
                k++;
            release_block(k, int'(p >> k));
            p += 64'd1 << k;
            c -= 64'd1 << k;
        end
    endfunction

    function automatic bit take_block(input int k, output int page);
        int j;
        int b;
        j = k;
        while (j <= MAX_ORDER && !order_busy[j]) j++;
        if (j > MAX_ORDER) return 1'b0;
        if (!lowest_free(j, b)) return 1'b0;
        free_map[map_pos(j, b)] = 1'b0;
        refresh_order(j);
        while (j > k) begin
            j--;
            b = b << 1;
            free_map[map_pos(j, b + 1)] = 1'b1;
            order_busy[j] = 1'b1;
        end
        page = b << k;
        return 1'b1;
    endfunction

    function automatic t_out_item predict_result(input t_in_item it);
        t_out_item r;
        longint    addr;
        longint    p;
        longint    cnt;
        int        ord;
        int        k;
        int        page;
        r.status        = ST_OK;
        r.alloc_address = '0;
        addr = longint'(it.byte_address);
        cnt  = longint'(it.page_count);
        ord  = int'(it.block_order);
        p    = addr >> PAGE_SHIFT;
        if (it.mode == MODE_ALLOC_CNT || it.mode == MODE_ALLOC_ORD) begin
            k = 0;
            if (it.mode == MODE_ALLOC_CNT) begin
                if (cnt == 0 || cnt > POOL_PAGES) r.status = ST_BADCOUNT;
                else while ((64'd1 << k) < cnt) k++;
            end else if (ord > MAX_ORDER) begin
                r.status = ST_BADCOUNT;
            end else begin
                k = ord;
            end
            if (r.status == ST_OK) begin
                if (!take_block(k, page)) begin
                    r.status = ST_NOMEM;
                end else begin
                    if (it.mode == MODE_ALLOC_CNT)
                        release_run(page + cnt, (64'd1 << k) - cnt);
                    r.alloc_address = ADDR_W'(longint'(page) << PAGE_SHIFT);
                end
            end
        end else if (addr >= longint'(free_limit)) begin
            r.status = ST_RANGE;
        end else if (addr % (64'd1 << PAGE_SHIFT) != 0) begin
            r.status = ST_PAGEALIGN;
        end else if (it.mode == MODE_FREE_CNT) begin
            if (cnt == 0) r.status = ST_BADCOUNT;
            else if (p + cnt > POOL_PAGES) r.status = ST_RANGE;
            else release_run(p, cnt);
        end else begin
            if (ord > MAX_ORDER || p + (64'd1 << ord) > POOL_PAGES) r.status = ST_RANGE;
            else if (p % (64'd1 << ord) != 0) r.status = ST_BLOCKALIGN;
            else release_block(ord, int'(p >> ord));
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            foreach (free_map[i]) free_map[i] = 1'b0;
            order_busy = '0;
            free_limit = LIMIT_RESET;
            expected_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected: status %0d address %h",
                             $time, i_out_data.status, i_out_data.alloc_address);
                    o_fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (want.status !== i_out_data.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, i_out_data.status);
                        o_fail_count++;
                    end
                    if (want.alloc_address !== i_out_data.alloc_address) begin
                        $display("%0t: alloc_address mismatch: expected %h, actual %h",
                                 $time, want.alloc_address, i_out_data.alloc_address);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_q.push_back(predict_result(i_in_data));
            if (i_cfg_we)
                free_limit = i_cfg_wdata;
        end
        o_pending = expected_q.size();
    end

endmodule

>>> tb/buddy_page_allocator_test.sv
// Top of the buddy page allocator testbench: clock, reset, request stimulus,
// receiver stalls and verdict. Depends on bpa_pkg, the design top and the checker module.
`timescale 1ns / 1ps

module buddy_page_allocator_test;
    import bpa_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int SETTLE      = 2000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    t_in_item           in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    t_out_item          out_data;
    logic               cfg_we = 1'b0;
    logic [LIMIT_W-1:0] cfg_wdata = '0;
    int                 fail_count;
    int                 pending;
    int                 cycles = 0;
    int                 burst_left = 0;
    bit                 hold_req = 1'b0;
    bit                 hold_ack = 1'b0;
    int                 hold_left = 0;
    int                 stall_style = 0;
    int                 style_left = 0;

    always #5 clk = ~clk;

    buddy_page_allocator u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    buddy_page_allocator_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // The receiver stalls in stretches of varying density, and holds off for
    // a long while whenever the stimulus asks for it.
    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left = 3000;
            out_stall <= 1'b1;
        end else begin
            if (style_left == 0) begin
                stall_style = $urandom_range(0, 3);
                style_left  = $urandom_range(20, 200);
            end
            style_left--;
            case (stall_style)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= 1'($urandom_range(0, 1));
                default: out_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    function automatic t_in_item make_req(input t_mode m, input int addr, input int cnt,
                                          input int ord);
        t_in_item it;
        it.mode         = m;
        it.byte_address = ADDR_W'(addr);
        it.page_count   = COUNT_W'(cnt);
        it.block_order  = BORD_W'(ord);
        return it;
    endfunction

    // Mostly well-formed requests over small blocks, so that the pool churns.
    function automatic t_in_item random_req();
        int pick;
        int ord;
        int cnt;
        int page;
        pick = $urandom_range(0, 99);
        ord  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 6);
        cnt  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 64);
        page = $urandom_range(0, POOL_PAGES - 1);
        if (pick < 10)
            return make_req(t_mode'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
        else if (pick < 33)
            return make_req(MODE_ALLOC_CNT, $urandom, cnt, $urandom);
        else if (pick < 55)
            return make_req(MODE_ALLOC_ORD, $urandom, $urandom, ord);
        else if (pick < 78) begin
            if (page + cnt > POOL_PAGES && $urandom_range(0, 3) != 0)
                page = POOL_PAGES - cnt;
            if (page < 0) page = 0;
            return make_req(MODE_FREE_CNT, page << PAGE_SHIFT, cnt, $urandom);
        end else begin
            page = page & ~((1 << ord) - 1);
            return make_req(MODE_FREE_ORD, page << PAGE_SHIFT, $urandom, ord);
        end
    endfunction

    task automatic send_req(input t_in_item it);
        in_data  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++) send_req(random_req());
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The pool starts empty, so the first beat hands it all over.
        send_req(make_req(MODE_FREE_ORD, 0, 0, 15));
        send_req(make_req(MODE_ALLOC_CNT, 0, 0, 0));
        send_req(make_req(MODE_ALLOC_CNT, 0, POOL_PAGES + 1, 0));
        send_req(make_req(MODE_ALLOC_CNT, 0, 65535, 15));
        send_req(make_req(MODE_ALLOC_CNT, 0, 1, 0));
        send_req(make_req(MODE_ALLOC_CNT, 0, 3, 0));
        send_req(make_req(MODE_ALLOC_CNT, 0, POOL_PAGES, 0));
        send_req(make_req(MODE_ALLOC_ORD, 0, 0, 0));
        send_req(make_req(MODE_ALLOC_ORD, 0, 0, 5));
        send_req(make_req(MODE_FREE_ORD, 32'h7ffffff, 0, 0));
        send_req(make_req(MODE_FREE_CNT, 32'h123, 1, 0));
        send_req(make_req(MODE_FREE_CNT, 32'h1000, 0, 0));
        send_req(make_req(MODE_FREE_CNT, 32'h7fff000, 2, 0));
        send_req(make_req(MODE_FREE_CNT, 0, 65535, 0));
        send_req(make_req(MODE_FREE_ORD, 32'h1000, 0, 15));
        send_req(make_req(MODE_FREE_ORD, 32'h1000, 0, 3));
        send_req(make_req(MODE_FREE_CNT, 0, 3, 0));
        send_req(make_req(MODE_FREE_ORD, 32'h4000, 0, 0));
        send_req(make_req(MODE_FREE_CNT, 0, POOL_PAGES, 0));
        send_req(make_req(MODE_ALLOC_ORD, 0, 0, 15));
        send_req(make_req(MODE_ALLOC_ORD, 0, 0, 15));
        send_req(make_req(MODE_FREE_ORD, 0, 0, 15));
        send_req(make_req(MODE_ALLOC_CNT, 0, POOL_PAGES, 0));
        send_req(make_req(MODE_FREE_CNT, 0, POOL_PAGES, 0));

        random_phase(100);
        // Long receiver hold-off while requests keep coming.
        hold_req <= ~hold_req;
        random_phase(100);
        drain();

        write_limit('0);
        random_phase(40);
        drain();
        write_limit(LIMIT_W'($urandom_range(1, 1 << ADDR_W)));
        random_phase(120);
        drain();
        write_limit(LIMIT_RESET);
        random_phase(140);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/bpa_pkg.sv
rtl/bpa_ram.sv
rtl/bpa_ctrl.sv
rtl/buddy_page_allocator.sv
tb/buddy_page_allocator_checker.sv
tb/buddy_page_allocator_test.sv
